// File: sv/mips_register_alu_execute_core_macros.svh
// Assertion helpers shared by the execute core and its register file.
`ifndef MIPS_REGISTER_ALU_EXECUTE_CORE_MACROS_SVH
`define MIPS_REGISTER_ALU_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication.
`define MRAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MRAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mrae_pkg.sv
`default_nettype none

package mrae_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned REG_COUNT  = 32;
   localparam int unsigned REG_ADDR_W = $clog2(REG_COUNT);
   localparam int unsigned IMM_W      = 16;
   localparam int unsigned IMM_SHIFT  = 16;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MULT = 4'd2,
      OP_AND  = 4'd3,
      OP_OR   = 4'd4,
      OP_SLL  = 4'd5,
      OP_SLT  = 4'd6,
      OP_ADDI = 4'd7,
      OP_SLTI = 4'd8,
      OP_LUI  = 4'd9,
      OP_LI   = 4'd10
   } mrae_op_type;

   typedef struct packed {
      logic [3:0]              operation;
      logic [REG_ADDR_W-1:0]   dest_reg;
      logic [REG_ADDR_W-1:0]   src_a_reg;
      logic [REG_ADDR_W-1:0]   src_b_reg;
      logic [4:0]              shift_amount;
      logic signed [IMM_W-1:0] immediate;
      logic signed [DATA_W-1:0] constant_value;
   } mrae_req_type;

   typedef struct packed {
      logic [REG_ADDR_W-1:0]    written_reg;
      logic signed [DATA_W-1:0] written_value;
      logic                     write_done;
   } mrae_rsp_type;

   // Register file write port.
   typedef struct packed {
      logic                  en;
      logic [REG_ADDR_W-1:0] addr;
      logic [DATA_W-1:0]     data;
   } mrae_wr_type;

endpackage

`default_nettype wire

// File: sv/mips_register_alu_execute_core.sv
`default_nettype none
`include "mips_register_alu_execute_core_macros.svh"

// Execute stage of a small MIPS-style core with a 32 x 32-bit register file.
// Request channel (req_valid / req_stall / req_payload): one decoded
// instruction per request; it is taken on an edge with req_valid high and
// req_stall low. Response channel (rsp_valid / rsp_stall / rsp_payload):
// one response per request, in order, giving the destination register, the
// computed value and whether the register file was updated.
// Throughput: one request per cycle when no stall holds the pipeline; the
// source operands are read from the register file at the accept edge and
// the ALU sits between that read and the response register.
// A result written on the same edge as a later request's read is bypassed,
// so back-to-back dependent instructions see the new value.
// Register 0 is never written; an unused opcode writes nothing and returns 0.
// Reset clears the pipeline valids and marks every register as zero at once
// (valid bits, no clearing pass), so requests are taken the cycle after.
// Stall: when rsp_stall holds a full response register the execute stage
// stops and req_stall rises; nothing is dropped or repeated.
module mips_register_alu_execute_core
   import mrae_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire mrae_req_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output mrae_rsp_type      rsp_payload
);

   // Handshake
   logic req_accept;
   logic s1_advance;

   // Execute stage register
   logic         s1_valid_ff, s1_valid_in;
   mrae_req_type s1_req_ff, s1_req_in;

   // Response register
   logic         rsp_valid_ff, rsp_valid_in;
   mrae_rsp_type rsp_ff, rsp_in;

   // Operands and ALU
   logic [DATA_W-1:0] opnd_a, opnd_b;
   logic [DATA_W-1:0] imm_ext;
   logic [DATA_W-1:0] alu_res;
   logic              op_ok;
   mrae_wr_type       rf_wr;
   mrae_rsp_type      result;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   // Operands are read at the accept edge.
   mrae_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_a_addr (req_payload.src_a_reg),
      .rd_b_addr (req_payload.src_b_reg),
      .wr        (rf_wr),
      .rd_a_data (opnd_a),
      .rd_b_data (opnd_b)
   );

   assign imm_ext = {{(DATA_W-IMM_W){s1_req_ff.immediate[IMM_W-1]}}, s1_req_ff.immediate};

   always_comb begin
      alu_res = '0;
      op_ok   = 1'b1;
      case (mrae_op_type'(s1_req_ff.operation))
         OP_ADD:  alu_res = opnd_a + opnd_b;
         OP_SUB:  alu_res = opnd_a - opnd_b;
         OP_MULT: alu_res = opnd_a * opnd_b;             // low word only
         OP_AND:  alu_res = opnd_a & opnd_b;
         OP_OR:   alu_res = opnd_a | opnd_b;
         OP_SLL:  alu_res = opnd_b << s1_req_ff.shift_amount;
         OP_SLT:  alu_res = {{(DATA_W-1){1'b0}}, ($signed(opnd_a) < $signed(opnd_b))};
         OP_ADDI: alu_res = opnd_a + imm_ext;
         OP_SLTI: alu_res = {{(DATA_W-1){1'b0}}, ($signed(opnd_a) < $signed(imm_ext))};
         OP_LUI:  alu_res = DATA_W'($unsigned(s1_req_ff.immediate)) << IMM_SHIFT;
         OP_LI:   alu_res = s1_req_ff.constant_value;
         default: op_ok   = 1'b0;                        // unused opcode
      endcase
   end

   always_comb begin
      rf_wr.en   = s1_advance && op_ok && (s1_req_ff.dest_reg != '0);
      rf_wr.addr = s1_req_ff.dest_reg;
      rf_wr.data = alu_res;

      result.written_reg   = s1_req_ff.dest_reg;
      result.written_value = alu_res;
      result.write_done    = op_ok && (s1_req_ff.dest_reg != '0);
   end

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_advance);
      s1_req_in    = req_accept ? req_payload : s1_req_ff;
      rsp_valid_in = s1_advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = s1_advance ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MRAE_ASSERT_NOW(a_done_not_r0, clock, reset, rsp_valid_ff && rsp_ff.write_done, rsp_ff.written_reg != '0, "r0 reported written")
   `MRAE_ASSERT_NOW(a_stall_needs_work, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall, "spurious request stall")
   `MRAE_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, s1_advance, rsp_valid_ff && (rsp_ff.written_reg == $past(s1_req_ff.dest_reg)), "response not loaded")

endmodule

`default_nettype wire

// File: sv/mrae_regfile.sv
`default_nettype none
`include "mips_register_alu_execute_core_macros.svh"

// 32 x 32 register file: two registered read ports, one write port.
// Valid bits give the zero reset; a last-write register bypasses a write
// that lands on the same edge as the read.
module mrae_regfile
   import mrae_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [REG_ADDR_W-1:0] rd_a_addr,
   input  wire logic [REG_ADDR_W-1:0] rd_b_addr,
   input  wire mrae_wr_type           wr,
   output logic [DATA_W-1:0]          rd_a_data,
   output logic [DATA_W-1:0]          rd_b_data
);

   logic [DATA_W-1:0]     mem [REG_COUNT];
   logic [REG_COUNT-1:0]  valid_ff, valid_in;

   logic [DATA_W-1:0]     rd_a_ff, rd_b_ff;
   logic                  rd_a_vld_ff, rd_b_vld_ff;
   logic [REG_ADDR_W-1:0] rd_a_addr_ff, rd_b_addr_ff;

   logic                  fwd_vld_ff, fwd_vld_in;
   logic [REG_ADDR_W-1:0] fwd_reg_ff, fwd_reg_in;
   logic [DATA_W-1:0]     fwd_data_ff, fwd_data_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff      <= mem[rd_a_addr];
         rd_b_ff      <= mem[rd_b_addr];
         rd_a_vld_ff  <= valid_ff[rd_a_addr];
         rd_b_vld_ff  <= valid_ff[rd_b_addr];
         rd_a_addr_ff <= rd_a_addr;
         rd_b_addr_ff <= rd_b_addr;
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      fwd_vld_in  = fwd_vld_ff;
      fwd_reg_in  = fwd_reg_ff;
      fwd_data_in = fwd_data_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
         fwd_vld_in        = 1'b1;
         fwd_reg_in        = wr.addr;
         fwd_data_in       = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         fwd_vld_ff <= fwd_vld_in;
      end
      fwd_reg_ff  <= fwd_reg_in;
      fwd_data_ff <= fwd_data_in;
   end

   // Latest write wins; unwritten entries read as zero.
   always_comb begin
      if (fwd_vld_ff && (fwd_reg_ff == rd_a_addr_ff)) begin
         rd_a_data = fwd_data_ff;
      end else if (rd_a_vld_ff) begin
         rd_a_data = rd_a_ff;
      end else begin
         rd_a_data = '0;
      end
      if (fwd_vld_ff && (fwd_reg_ff == rd_b_addr_ff)) begin
         rd_b_data = fwd_data_ff;
      end else if (rd_b_vld_ff) begin
         rd_b_data = rd_b_ff;
      end else begin
         rd_b_data = '0;
      end
   end

   `MRAE_ASSERT_NOW(a_no_r0_write, clock, reset, wr.en, wr.addr != '0, "write to r0")
   `MRAE_ASSERT_NOW(a_r0_never_valid, clock, reset, 1'b1, !valid_ff[0], "r0 marked valid")
   `MRAE_ASSERT_NEXT(a_fwd_tracks_write, clock, reset, wr.en, fwd_vld_ff && (fwd_reg_ff == $past(wr.addr)) && (fwd_data_ff == $past(wr.data)), "bypass lost a write")

endmodule

`default_nettype wire
